>>> rtl/gntia_pkg.sv
`timescale 1ns / 1ps

package gntia_pkg;

  // Table geometry
  localparam int MAX_TARGETS = 8;
  localparam int IDX_W       = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CNT_W       = $clog2(MAX_TARGETS + 1);
  localparam int ADDR_W      = IDX_W + 1;
  localparam int MEM_DEPTH   = 2 * (1 << IDX_W);

  // Field widths
  localparam int COORD_W  = 16;
  localparam int CENTER_W = COORD_W + 1;
  localparam int TRACK_W  = 16;
  localparam int TIME_W   = 32;
  localparam int LIVE_W   = 4;
  localparam int SQ_W     = 2 * CENTER_W;
  localparam int DIST_W   = SQ_W + 1;

  localparam logic [COORD_W-1:0] COORD_MAX = '1;

  // Item kinds carried on in_tuser
  typedef enum logic [1:0] {
    FUNC_BEGIN = 2'd0,
    FUNC_BODY  = 2'd1,
    FUNC_PRUNE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_MIRROR_X  = 2'd0;
  localparam logic [1:0] CFG_MAX_DIST  = 2'd1;
  localparam logic [1:0] CFG_MAX_AGE   = 2'd2;

  localparam logic [15:0] MAX_DIST_RST = 16'd9830;
  localparam logic [15:0] MAX_AGE_RST  = 16'd350;

  // One table entry as held in memory
  typedef struct packed {
    logic [CENTER_W-1:0] cx;
    logic [CENTER_W-1:0] cy;
    logic [TRACK_W-1:0]  track;
    logic [TIME_W-1:0]   seen;
  } entry_t;

  // One result item
  typedef struct packed {
    logic [LIVE_W-1:0]  live_count;
    logic [COORD_W-1:0] out_max_x;
    logic [COORD_W-1:0] out_min_x;
    logic               stored;
    logic               reused;
    logic [TRACK_W-1:0] track_id;
  } result_t;

endpackage

>>> rtl/greedy_nearest_track_id_assign.sv
`timescale 1ns / 1ps
// Begin-frame and unused codes need no table scan; a body item and a prune each walk the
//   previous table, whose fill is 0..8.
// Throughput: one item in flight; the scan reads one table entry per cycle from the
//   entry memory, so the next item is taken once the result is registered.
// Reset (rst_n low, synchronous): tables empty, used marks clear, fresh id 0,
//   registers at mirror off, distance 9830, age 350 ms. The memory itself is not cleared.
module greedy_nearest_track_id_assign (
  input  logic         clk,
  input  logic         rst_n,
  // input items
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: timestamp_ms[31:0], box_min_x[47:32], box_min_y[63:48],
  //        box_max_x[79:64], box_max_y[95:80]
  input  logic [95:0]  in_tdata,
  // tuser: func[1:0]
  input  logic [1:0]   in_tuser,
  // result items
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: track_id[15:0], reused[16], stored[17], out_min_x[33:18],
  //        out_max_x[49:34], live_count[53:50], zero fill[55:54]
  output logic [55:0]  out_tdata,
  // configuration writes
  input  logic         cfg_we,
  input  logic [1:0]   cfg_idx,
  input  logic [15:0]  cfg_wdata
);
  import gntia_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_PRUNE  = 5'b00100,
    ST_COMMIT = 5'b01000,
    ST_FIN    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic        mirror_x_r;
  logic [15:0] max_dist_r;
  logic [15:0] max_age_r;

  // table control
  logic                   sel_r;       // bank holding the current table
  logic [CNT_W-1:0]       cur_cnt_r;
  logic [CNT_W-1:0]       prev_cnt_r;
  logic [MAX_TARGETS-1:0] taken_r;
  logic [TRACK_W-1:0]     fresh_id_r;

  // item registers
  logic [TIME_W-1:0]   now_r;
  logic [COORD_W-1:0]  omin_r, omax_r;
  logic [CENTER_W-1:0] cx_r, cy_r;
  logic [TRACK_W-1:0]  id_r;
  logic                reused_r, stored_r;

  // scan pipeline
  logic [CNT_W-1:0]    rd_cnt_r;
  logic                v1_r, v2_r;
  logic [IDX_W-1:0]    idx1_r, idx2_r;
  logic [TRACK_W-1:0]  track2_r;
  logic [SQ_W-1:0]     sqx_r, sqy_r;
  logic [DIST_W-1:0]   best_r;
  logic [IDX_W-1:0]    best_idx_r;
  logic [TRACK_W-1:0]  best_track_r;
  logic                found_r;

  // entry memory, two banks of MAX_TARGETS entries
  entry_t              mem [MEM_DEPTH];
  entry_t              rd_data_r;
  logic [ADDR_W-1:0]   rd_addr, wr_addr;
  logic                mem_we;
  entry_t              wr_data;

  // output register
  logic    out_valid_r;
  result_t out_r;

  // decoded input fields
  logic [1:0]         in_func;
  logic [TIME_W-1:0]  in_ts;
  logic [COORD_W-1:0] in_min_x, in_min_y, in_max_x, in_max_y;
  logic [COORD_W-1:0] m_min_x, m_max_x;
  logic               in_acc;

  assign in_func  = in_tuser;
  assign in_ts    = in_tdata[31:0];
  assign in_min_x = in_tdata[47:32];
  assign in_min_y = in_tdata[63:48];
  assign in_max_x = in_tdata[79:64];
  assign in_max_y = in_tdata[95:80];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign m_min_x = mirror_x_r ? (COORD_MAX - in_max_x) : in_min_x;
  assign m_max_x = mirror_x_r ? (COORD_MAX - in_min_x) : in_max_x;

  // scan control
  logic             rd_done;
  logic             issue;
  logic [IDX_W-1:0] rd_idx;
  logic             scan_end, prune_end, cur_full;
  logic             out_free;
  logic             keep;

  assign rd_idx   = rd_cnt_r[IDX_W-1:0];
  assign rd_done  = (rd_cnt_r == prev_cnt_r);
  assign issue    = !rd_done && ((state_r == ST_PRUNE) ||
                                 ((state_r == ST_SCAN) && !taken_r[rd_idx]));
  assign scan_end  = (state_r == ST_SCAN) && rd_done && !v1_r && !v2_r;
  assign prune_end = (state_r == ST_PRUNE) && rd_done && !v1_r;
  assign cur_full  = (cur_cnt_r == CNT_W'(MAX_TARGETS));
  assign out_free  = !out_valid_r || out_tready;
  assign keep      = (TIME_W'(now_r - rd_data_r.seen) <= TIME_W'(max_age_r));

  assign rd_addr = {~sel_r, rd_idx};
  assign wr_addr = {sel_r, cur_cnt_r[IDX_W-1:0]};

  // memory write: body append or kept entry during prune
  always_comb begin
    mem_we  = 1'b0;
    wr_data = rd_data_r;
    if (state_r == ST_COMMIT && !cur_full) begin
      mem_we        = 1'b1;
      wr_data.cx    = cx_r;
      wr_data.cy    = cy_r;
      wr_data.track = found_r ? best_track_r : fresh_id_r;
      wr_data.seen  = now_r;
    end else if (state_r == ST_PRUNE && v1_r && keep) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_func)
            FUNC_BODY:  state_nxt = ST_SCAN;
            FUNC_PRUNE: state_nxt = ST_PRUNE;
            default:    state_nxt = ST_FIN;
          endcase
        end
      end
      ST_SCAN:   if (scan_end) state_nxt = ST_COMMIT;
      ST_PRUNE:  if (prune_end) state_nxt = ST_FIN;
      ST_COMMIT: state_nxt = ST_FIN;
      ST_FIN:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mirror_x_r  <= 1'b0;
      max_dist_r  <= MAX_DIST_RST;
      max_age_r   <= MAX_AGE_RST;
      sel_r       <= 1'b0;
      cur_cnt_r   <= '0;
      prev_cnt_r  <= '0;
      taken_r     <= '0;
      fresh_id_r  <= '0;
      rd_cnt_r    <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // register writes
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MIRROR_X: mirror_x_r <= cfg_wdata[0];
          CFG_MAX_DIST: max_dist_r <= cfg_wdata;
          CFG_MAX_AGE:  max_age_r  <= cfg_wdata;
          default:      ;
        endcase
      end

      // item start: begin and prune swap banks so the current table becomes previous
      if (in_acc) begin
        rd_cnt_r <= '0;
        found_r  <= 1'b0;
        if (in_func == FUNC_BEGIN || in_func == FUNC_PRUNE) begin
          sel_r      <= ~sel_r;
          prev_cnt_r <= cur_cnt_r;
          cur_cnt_r  <= '0;
          taken_r    <= '0;
        end
      end

      // read issue
      if (state_r == ST_SCAN || state_r == ST_PRUNE) begin
        if (!rd_done) begin
          rd_cnt_r <= rd_cnt_r + CNT_W'(1);
        end
      end
      v1_r <= issue;
      v2_r <= v1_r && (state_r == ST_SCAN);

      // nearest candidate so far
      if (v2_r && ({1'b0, sqx_r} + {1'b0, sqy_r} < best_r)) begin
        found_r <= 1'b1;
      end

      // prune keeps fresh entries in order
      if (state_r == ST_PRUNE && v1_r && keep) begin
        cur_cnt_r <= cur_cnt_r + CNT_W'(1);
      end

      // body commit: take the matched id or issue a fresh one, then append if the table has room
      if (state_r == ST_COMMIT) begin
        if (found_r) begin
          taken_r[best_idx_r] <= 1'b1;
        end else begin
          fresh_id_r <= fresh_id_r + TRACK_W'(1);
        end
        if (!cur_full) begin
          cur_cnt_r <= cur_cnt_r + CNT_W'(1);
        end
      end

      // output register
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  logic [CENTER_W-1:0] dx, dy;
  logic [CENTER_W-1:0] lim2;

  assign lim2 = {max_dist_r, 1'b0};
  assign dx = (cx_r >= rd_data_r.cx) ? (cx_r - rd_data_r.cx) : (rd_data_r.cx - cx_r);
  assign dy = (cy_r >= rd_data_r.cy) ? (cy_r - rd_data_r.cy) : (rd_data_r.cy - cy_r);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r    <= in_ts;
      reused_r <= 1'b0;
      stored_r <= 1'b0;
      id_r     <= '0;
      best_r   <= DIST_W'(lim2) * DIST_W'(lim2);
      if (in_func == FUNC_BODY) begin
        omin_r <= m_min_x;
        omax_r <= m_max_x;
        cx_r   <= CENTER_W'(m_min_x) + CENTER_W'(m_max_x);
        cy_r   <= CENTER_W'(in_min_y) + CENTER_W'(in_max_y);
      end else begin
        omin_r <= '0;
        omax_r <= '0;
      end
    end

    // squares of the axis distances
    idx1_r   <= rd_idx;
    idx2_r   <= idx1_r;
    track2_r <= rd_data_r.track;
    sqx_r    <= SQ_W'(dx) * SQ_W'(dx);
    sqy_r    <= SQ_W'(dy) * SQ_W'(dy);

    if (v2_r && ({1'b0, sqx_r} + {1'b0, sqy_r} < best_r)) begin
      best_r       <= {1'b0, sqx_r} + {1'b0, sqy_r};
      best_idx_r   <= idx2_r;
      best_track_r <= track2_r;
    end

    if (state_r == ST_COMMIT) begin
      id_r     <= found_r ? best_track_r : fresh_id_r;
      reused_r <= found_r;
      stored_r <= !cur_full;
    end

    if (state_r == ST_FIN && out_free) begin
      out_r.track_id   <= id_r;
      out_r.reused     <= reused_r;
      out_r.stored     <= stored_r;
      out_r.out_min_x  <= omin_r;
      out_r.out_max_x  <= omax_r;
      out_r.live_count <= LIVE_W'(cur_cnt_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r};

  // checks
  a_cur_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_cnt_r <= CNT_W'(MAX_TARGETS))
    else $error("current table count beyond depth");

  a_taken_within_prev: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(taken_r) <= prev_cnt_r)
    else $error("used marks exceed previous table fill");

  a_fresh_only_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (fresh_id_r != $past(fresh_id_r)) |-> ($past(state_r) == ST_COMMIT))
    else $error("fresh id advanced outside body commit");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (state_r == ST_SCAN))
    else $error("distance stage active outside body scan");

endmodule
